/* src/tep_pkg.sv */
// tep_pkg: shared types, constants and the CORDIC arctangent table for the tunnel pixel mapper
// no dependencies
`default_nettype none
package tep_pkg;
	localparam int MAX_SIZE_LOG2 = 11;
	localparam int CORDIC_STEPS = 16;
	localparam int CFG_DW = 12;
	localparam int CFG_IW = 3;

	localparam logic [CFG_IW-1:0] REG_SIZE_LOG2 = 3'd0;
	localparam logic [CFG_IW-1:0] REG_SCREEN_W = 3'd1;
	localparam logic [CFG_IW-1:0] REG_SCREEN_H = 3'd2;
	localparam logic [CFG_IW-1:0] REG_SHIFT_X = 3'd3;
	localparam logic [CFG_IW-1:0] REG_SHIFT_Y = 3'd4;

	typedef struct packed {
		logic [10:0] pixel_x;
		logic [10:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic [10:0] texel_x;
		logic [10:0] texel_y;
		logic [7:0]  blue_level;
		logic        at_center;
	} texel_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
			3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
			9: r = 32'h00145F2F;  10: r = 32'h000A2F98; 11: r = 32'h000517CC;
			12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
			15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
			18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
			21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

/* src/tunnel_effect_pixel_mapper.sv */
// tunnel_effect_pixel_mapper: screen pixel to tunnel texel, fully pipelined
// depends on tep_pkg
//
// channel   direction  handshake          payload
// pixel     in         start & !busy      pixel_t  (pixel_x, pixel_y)
// texel     out        done (one cycle)   texel_t  (texel_x, texel_y, blue_level, at_center)
// cfg       in         cfg_we             cfg_index, cfg_data
//
// one pixel enters every clock; busy is never raised
// done follows the accepted pixel through the offset stage, the bit-per-stage divider
// and the two-bits-per-stage square root to the output register; the CORDIC stages
// run alongside the divider
// arst_n clears the valid bits and loads the register defaults; the receiver cannot stall
`default_nettype none
module tunnel_effect_pixel_mapper
	import tep_pkg::*;
#(
	parameter int MAX_SIZE_LOG2_P = MAX_SIZE_LOG2,
	parameter int CORDIC_STEPS_P = CORDIC_STEPS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire pixel_t            pixel,
	output logic                   done,
	output texel_t                 texel,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data
);
	localparam int ML = MAX_SIZE_LOG2_P;
	localparam int CS = CORDIC_STEPS_P;
	localparam int KW = $clog2(ML + 1);
	localparam int NW = ML + 1;
	localparam int DW = ((ML > 12) ? ML : 12) + 3;
	localparam int D2W = 2 * DW;
	localparam int QW = 2 * ML + 11;
	localparam int PW = $clog2(QW);
	localparam int SQ = (QW + 1) / 2;
	localparam int CW = DW + 19;
	localparam int ZW = 34;
	localparam int NA = (QW > CS) ? QW : CS;
	localparam int AW = ML + 4;

	// configuration registers
	logic [3:0]  size_q;
	logic [11:0] sw_q, sh_q;
	logic [10:0] sx_q, sy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 4'd10;
			sw_q <= 12'd640;
			sh_q <= 12'd480;
			sx_q <= '0;
			sy_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIZE_LOG2: size_q <= cfg_data[3:0];
				REG_SCREEN_W: sw_q <= cfg_data[11:0];
				REG_SCREEN_H: sh_q <= cfg_data[11:0];
				REG_SHIFT_X: sx_q <= cfg_data[10:0];
				REG_SHIFT_Y: sy_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// derived configuration; the user keeps it stable while items are in flight, the block does not enforce this
	logic [KW-1:0]        kc;
	logic [NW-1:0]        n_w, mask, half_n;
	logic signed [DW-1:0] diff_x, diff_y, look_x, look_y;
	logic [PW-1:0]        num_pos;

	always_comb begin
		if (size_q < 4'd3) kc = KW'(3);
		else if (32'(size_q) > ML) kc = KW'(ML);
		else kc = KW'(size_q);
		n_w = NW'(1) << kc;
		mask = n_w - NW'(1);
		half_n = n_w >> 1;
		diff_x = $signed(DW'(n_w) - DW'(sw_q));
		diff_y = $signed(DW'(n_w) - DW'(sh_q));
		// halve, truncating toward zero
		look_x = $signed(diff_x + DW'(diff_x < 0)) >>> 1;
		look_y = $signed(diff_y + DW'(diff_y < 0)) >>> 1;
		num_pos = PW'(10) + PW'({kc, 1'b0});
	end

	assign busy = 1'b0;

	// stage 1: offsets from the tunnel centre
	logic                 v_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		dx_s1 <= $signed(DW'(pixel.pixel_x) + look_x - $signed(DW'(half_n)));
		dy_s1 <= $signed(DW'(pixel.pixel_y) + look_y - $signed(DW'(half_n)));
	end

	// phase a: divider and CORDIC side by side, index 0 is the stage 2 register
	logic                  va  [0:NA];
	logic [D2W-1:0]        rem_a [0:NA];
	logic [D2W-1:0]        d2_a  [0:NA];
	logic [QW-1:0]         q_a   [0:NA];
	logic                  cen_a [0:NA];
	logic signed [CW-1:0]  cx_a  [0:NA];
	logic signed [CW-1:0]  cy_a  [0:NA];
	logic signed [ZW-1:0]  z_a   [0:NA];

	logic signed [CW-1:0] cx0, cy0;
	logic signed [ZW-1:0] z0;

	always_comb begin
		cx0 = $signed({{(CW-DW-16){dx_s1[DW-1]}}, dx_s1, 16'b0});
		cy0 = $signed({{(CW-DW-16){dy_s1[DW-1]}}, dy_s1, 16'b0});
		z0 = '0;
		// left half plane: flip the vector and start half a turn around
		if (dx_s1 < 0) begin
			cx0 = -cx0;
			cy0 = -cy0;
			z0 = (dy_s1 >= 0) ? $signed(ZW'(64'sh80000000)) : -$signed(ZW'(64'sh80000000));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) va[0] <= 1'b0;
		else va[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		d2_a[0] <= D2W'(dx_s1 * dx_s1) + D2W'(dy_s1 * dy_s1);
		cen_a[0] <= (dx_s1 == 0) && (dy_s1 == 0);
		rem_a[0] <= '0;
		q_a[0] <= '0;
		cx_a[0] <= cx0;
		cy_a[0] <= cy0;
		z_a[0] <= z0;
	end

	for (genvar j = 0; j < NA; j++) begin : g_a
		logic [D2W:0]         trial;
		logic [D2W-1:0]       rem_n;
		logic [QW-1:0]        q_n;
		logic signed [CW-1:0] cx_n, cy_n, sx, sy;
		logic signed [ZW-1:0] z_n;

		always_comb begin
			rem_n = rem_a[j];
			q_n = q_a[j];
			if (j < QW) begin
				// numerator is a single one at bit 10 + 2k
				trial = {rem_a[j], num_pos == PW'(QW - 1 - j)};
				if (trial >= {1'b0, d2_a[j]}) begin
					rem_n = D2W'(trial - {1'b0, d2_a[j]});
					q_n = {q_a[j][QW-2:0], 1'b1};
				end else begin
					rem_n = trial[D2W-1:0];
					q_n = {q_a[j][QW-2:0], 1'b0};
				end
			end else begin
				trial = '0;
			end
			cx_n = cx_a[j];
			cy_n = cy_a[j];
			z_n = z_a[j];
			sx = cx_a[j] >>> j;
			sy = cy_a[j] >>> j;
			if (j < CS) begin
				if (cy_a[j] > 0) begin
					cx_n = cx_a[j] + sy;
					cy_n = cy_a[j] - sx;
					z_n = z_a[j] + $signed(ZW'(atan_turn(j)));
				end else begin
					cx_n = cx_a[j] - sy;
					cy_n = cy_a[j] + sx;
					z_n = z_a[j] - $signed(ZW'(atan_turn(j)));
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) va[j+1] <= 1'b0;
			else va[j+1] <= va[j];
		end

		always_ff @(posedge clk) begin
			rem_a[j+1] <= rem_n;
			q_a[j+1] <= q_n;
			d2_a[j+1] <= d2_a[j];
			cen_a[j+1] <= cen_a[j];
			cx_a[j+1] <= cx_n;
			cy_a[j+1] <= cy_n;
			z_a[j+1] <= z_n;
		end
	end

	// angle from the accumulator, truncated toward zero
	logic [ZW-1:0]        zabs, zsh;
	logic signed [AW-1:0] ang_w;

	always_comb begin
		zabs = (z_a[NA] < 0) ? ZW'(-z_a[NA]) : ZW'(z_a[NA]);
		zsh = zabs >> (6'd32 - 6'(kc));
		ang_w = (z_a[NA] < 0) ? -$signed(AW'(zsh)) : $signed(AW'(zsh));
	end

	// phase b: square root, two radicand bits per stage
	logic                 vb    [0:SQ];
	logic [SQ+1:0]        rem_b [0:SQ];
	logic [SQ-1:0]        root_b [0:SQ];
	logic [2*SQ-1:0]      rad_b [0:SQ];
	logic signed [AW-1:0] ang_b [0:SQ];
	logic                 cen_b [0:SQ];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vb[0] <= 1'b0;
		else vb[0] <= va[NA];
	end

	always_ff @(posedge clk) begin
		rem_b[0] <= '0;
		root_b[0] <= '0;
		rad_b[0] <= (2*SQ)'(q_a[NA]);
		ang_b[0] <= cen_a[NA] ? '0 : ang_w;
		cen_b[0] <= cen_a[NA];
	end

	for (genvar m = 0; m < SQ; m++) begin : g_b
		logic [SQ+3:0] cur, tr;
		logic [SQ+1:0] rem_n;
		logic [SQ-1:0] root_n;

		always_comb begin
			cur = {rem_b[m], rad_b[m][2*(SQ-1-m)+1 -: 2]};
			tr = (SQ+4)'({root_b[m], 2'b01});
			if (cur >= tr) begin
				rem_n = (SQ+2)'(cur - tr);
				root_n = {root_b[m][SQ-2:0], 1'b1};
			end else begin
				rem_n = cur[SQ+1:0];
				root_n = {root_b[m][SQ-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vb[m+1] <= 1'b0;
			else vb[m+1] <= vb[m];
		end

		always_ff @(posedge clk) begin
			rem_b[m+1] <= rem_n;
			root_b[m+1] <= root_n;
			rad_b[m+1] <= rad_b[m];
			ang_b[m+1] <= ang_b[m];
			cen_b[m+1] <= cen_b[m];
		end
	end

	// output stage: texture coordinates and the xor pattern
	logic [NW-1:0]   dist_w, tx, ty;
	logic [NW+7:0]   bx, by;

	always_comb begin
		dist_w = cen_b[SQ] ? '0 : NW'(root_b[SQ]);
		tx = (dist_w + NW'(sx_q) + NW'(look_x)) & mask;
		ty = (NW'(ang_b[SQ]) + NW'(sy_q) + NW'(look_y)) & mask;
		bx = {tx, 8'b0} >> kc;
		by = {ty, 8'b0} >> kc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vb[SQ];
	end

	always_ff @(posedge clk) begin
		texel.texel_x <= 11'(tx);
		texel.texel_y <= 11'(ty);
		texel.blue_level <= bx[7:0] ^ by[7:0];
		texel.at_center <= cen_b[SQ];
	end
endmodule
`default_nettype wire

/* src/tep_checker.sv */
// tep_checker: port-level checks for tunnel_effect_pixel_mapper, with its bind
// depends on tep_pkg
`default_nettype none
module tep_checker
	import tep_pkg::*;
#(
	parameter int LAT = 4 + ((2*MAX_SIZE_LOG2+11 > CORDIC_STEPS) ?
		2*MAX_SIZE_LOG2+11 : CORDIC_STEPS) + (MAX_SIZE_LOG2 + 6)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);
	// the block takes a beat every cycle
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// every result beat traces back to an accepted beat a fixed latency earlier
	a_done_has_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result beat without accepted input");

	// reset empties the pipeline
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !done)
		else $error("result beat during reset");
endmodule

bind tunnel_effect_pixel_mapper tep_checker #(
	.LAT(4 + ((2*MAX_SIZE_LOG2_P+11 > CORDIC_STEPS_P) ?
		2*MAX_SIZE_LOG2_P+11 : CORDIC_STEPS_P) + (MAX_SIZE_LOG2_P + 6))
) u_tep_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done)
);
`default_nettype wire

/* verif/testbench.sv */
// testbench: checks the tunnel pixel mapper against a predictor of angle, distance and texel
// depends on tep_pkg and tunnel_effect_pixel_mapper
`default_nettype none
module testbench;
	import tep_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 3 + 33 + 17;
	localparam int CYCLE_LIMIT = 300000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	pixel_t pixel = '0;
	logic done;
	texel_t texel;
	logic cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = REG_SIZE_LOG2;
	logic [CFG_DW-1:0] cfg_data = '0;

	// register copies for the predictor
	logic [3:0] size_reg = 4'd10;
	logic [11:0] width_reg = 12'd640;
	logic [11:0] height_reg = 12'd480;
	logic [10:0] scroll_reg = '0;
	logic [10:0] spin_reg = '0;

	pixel_t pixel_queue[$];
	texel_t texel_queue[$];
	int mismatches = 0;
	int cycles = 0;
	logic no_gaps = 1'b0;

	const longint ATAN_TURNS[24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
		64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
		64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	tunnel_effect_pixel_mapper DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixel(pixel),
		.done(done), .texel(texel), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint root_floor(longint v);
		longint r, b;
		r = 0;
		b = longint'(1) << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint tunnel_angle(longint dx, longint dy, int k);
		longint cx, cy, z, sx, sy;
		cx = dx * 65536;
		cy = dy * 65536;
		z = 0;
		if (dx < 0) begin
			z = (dy >= 0) ? (longint'(1) << 31) : -(longint'(1) << 31);
			cx = -cx;
			cy = -cy;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			sx = cx >>> i;
			sy = cy >>> i;
			if (cy > 0) begin
				cx = cx + sy;
				cy = cy - sx;
				z = z + ATAN_TURNS[i];
			end else begin
				cx = cx - sy;
				cy = cy + sx;
				z = z - ATAN_TURNS[i];
			end
		end
		return (z >= 0) ? (z >> (32 - k)) : -((-z) >> (32 - k));
	endfunction

	function automatic int eff_log2();
		return (size_reg < 3) ? 3 : (size_reg > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : int'(size_reg);
	endfunction

	function automatic texel_t map_pixel(pixel_t p);
		int k;
		longint n, mask, lx, ly, dx, dy, d2, dist_val, ang, tx, ty;
		texel_t t;
		k = eff_log2();
		n = longint'(1) << k;
		mask = n - 1;
		lx = (n - longint'(width_reg)) / 2;
		ly = (n - longint'(height_reg)) / 2;
		dx = longint'(p.pixel_x) + lx - n / 2;
		dy = longint'(p.pixel_y) + ly - n / 2;
		d2 = dx * dx + dy * dy;
		dist_val = 0;
		ang = 0;
		if (d2 != 0) begin
			dist_val = root_floor((1024 * n * n) / d2) & mask;
			ang = tunnel_angle(dx, dy, k);
		end
		tx = (dist_val + longint'(scroll_reg) + lx) & mask;
		ty = (ang + longint'(spin_reg) + ly) & mask;
		t.texel_x = tx[10:0];
		t.texel_y = ty[10:0];
		t.blue_level = 8'(((tx << 8) >> k) ^ ((ty << 8) >> k));
		t.at_center = (d2 == 0);
		return t;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d", field, got, want);
		mismatches++;
	endtask

	// driver: one beat per accept, random gaps except in the gap-free phase
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) texel_queue.push_back(map_pixel(pixel));
			if (!start || !busy) begin
				if (pixel_queue.size() > 0 && (no_gaps || $urandom_range(99) >= 20)) begin
					start <= 1'b1;
					pixel <= pixel_queue.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (texel_queue.size() == 0) begin
				$display("unexpected texel beat");
				mismatches++;
			end else begin
				texel_t want;
				want = texel_queue.pop_front();
				if (texel.texel_x !== want.texel_x)
					report_mismatch("texel_x", texel.texel_x, want.texel_x);
				if (texel.texel_y !== want.texel_y)
					report_mismatch("texel_y", texel.texel_y, want.texel_y);
				if (texel.blue_level !== want.blue_level)
					report_mismatch("blue_level", texel.blue_level, want.blue_level);
				if (texel.at_center !== want.at_center)
					report_mismatch("at_center", texel.at_center, want.at_center);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic write_regs(int sz, int w, int h, int sx, int sy);
		int vals[5];
		vals = '{sz, w, h, sx, sy};
		for (int i = 0; i < 5; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= CFG_IW'(i);
			cfg_data <= CFG_DW'(vals[i]);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = 4'(sz);
		width_reg = 12'(w);
		height_reg = 12'(h);
		scroll_reg = 11'(sx);
		spin_reg = 11'(sy);
	endtask

	task automatic drain();
		while (pixel_queue.size() > 0 || start || texel_queue.size() > 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic pixel_t at_offset(int ox, int oy);
		longint n, cx, cy;
		pixel_t p;
		n = longint'(1) << eff_log2();
		cx = n / 2 - (n - longint'(width_reg)) / 2 + ox;
		cy = n / 2 - (n - longint'(height_reg)) / 2 + oy;
		p.pixel_x = 11'(cx);
		p.pixel_y = 11'(cy);
		return p;
	endfunction

	initial begin
		int k, n, oxs[9], oys[9];
		pixel_t p;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: center, both axes, all four quadrants, field extremes
		oxs = '{0, 5, -5, 0, 0, 7, -7, -7, 7};
		oys = '{0, 0, 0, 5, -5, 7, 7, -7, -7};
		for (int i = 0; i < 9; i++) pixel_queue.push_back(at_offset(oxs[i], oys[i]));
		pixel_queue.push_back('{11'd0, 11'd0});
		pixel_queue.push_back('{11'd2047, 11'd2047});
		pixel_queue.push_back('{11'd0, 11'd2047});
		pixel_queue.push_back('{11'd2047, 11'd0});
		pixel_queue.push_back('{11'h555, 11'h2AA});
		pixel_queue.push_back('{11'h2AA, 11'h555});
		drain();

		for (int ph = 0; ph < 14; ph++) begin
			case (ph)
				0: write_regs(0, 1, 1, 0, 0);
				1: write_regs(3, 8, 8, 2047, 2047);
				2: write_regs(11, 2048, 2048, 1, 2046);
				3: write_regs(15, 4095, 4095, 2047, 0);
				4: write_regs(12, 1, 4095, 0, 2047);
				default: begin
					k = $urandom_range(15);
					n = 1 << ((k < 3) ? 3 : (k > 11) ? 11 : k);
					write_regs(k,
						($urandom_range(9) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, n),
						($urandom_range(9) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, n),
						$urandom_range(2047), $urandom_range(2047));
				end
			endcase
			no_gaps = (ph == 7);
			n = 1 << eff_log2();
			for (int i = 0; i < 128; i++) begin
				case ($urandom_range(3))
					0: p = '{11'($urandom_range(2047)), 11'($urandom_range(2047))};
					1: p = at_offset($urandom_range(6) - 3, $urandom_range(6) - 3);
					default: p = at_offset($urandom_range(n) - n / 2, $urandom_range(n) - n / 2);
				endcase
				pixel_queue.push_back(p);
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
